// ----- rtl/pgst_pkg.sv -----
// ----------------------------------------------------------------------------
// pgst_pkg
// Types and constants shared by the pinch scale tracker and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package pgst_pkg;

  localparam int CMD_BITS    = 2;
  localparam int ID_BITS     = 8;
  localparam int COORD_BITS  = 12;
  localparam int DIST_BITS   = 21;
  localparam int RATIO_BITS  = 32;
  localparam int FRAC_SHIFT  = 16;
  localparam int PAIR_COUNT  = 2;

  // sqrt works on two radicand bits per step, divide on one dividend bit
  localparam int RAD_BITS    = 2 * DIST_BITS;
  localparam int DVD_BITS    = DIST_BITS + FRAC_SHIFT;
  localparam int SQRT_STEPS  = DIST_BITS;
  localparam int UNIT_BITS   = DIST_BITS + 3;
  localparam int STEP_BITS   = $clog2(DVD_BITS + 1);
  localparam int SQ_BITS     = 2 * COORD_BITS;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_MOVE    = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]   command;
    logic [ID_BITS-1:0]    pointer_id;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
  } evt_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0] scale_ratio;
    logic [DIST_BITS-1:0]  current_distance;
    logic                  base_was_zero;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/pgst_ifs.sv -----
// ----------------------------------------------------------------------------
// pgst channel interfaces
// Valid/ready channels for touch event requests and scale results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pgst_evt_if;
  logic            valid;
  logic            ready;
  pgst_pkg::evt_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pgst_res_if;
  logic            valid;
  logic            ready;
  pgst_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pinch_gesture_scale_tracker.sv -----
// ----------------------------------------------------------------------------
// pinch_gesture_scale_tracker
// Touch pointer list with pinch distance and Q16.16 scale ratio output.
// ----------------------------------------------------------------------------
// Takes one touch request at a time; ready is high only while idle. A press
// that brings the list to two pointers also computes the base distance. A
// release or move walks the list, one entry per cycle. A move that leaves two
// pointers then runs difference and squaring on one 12x12 multiplier, 21
// square-root steps and, for a nonzero base, 37 divide steps, all on one shared
// 24-bit subtractor, and then hands the result to the output register, waiting
// while the output register is still full. The result register lets the next
// request in while a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pinch_gesture_scale_tracker #(
  parameter int MAX_POINTERS = 8
) (
  input  wire             clk,
  input  wire             rst,
  pgst_evt_if.sink        evt,
  pgst_res_if.source      res
);

  localparam int IDX_W = (MAX_POINTERS > 1) ? $clog2(MAX_POINTERS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTERS + 1);
  localparam int CW    = pgst_pkg::COORD_BITS;
  localparam int DW    = pgst_pkg::DIST_BITS;
  localparam int UW    = pgst_pkg::UNIT_BITS;
  localparam int RW    = pgst_pkg::RAD_BITS;
  localparam int VW    = pgst_pkg::DVD_BITS;
  localparam int SW    = pgst_pkg::STEP_BITS;
  localparam int QW    = pgst_pkg::RATIO_BITS;

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_POINTERS);
  localparam logic [CNT_W-1:0] PAIR_CNT = CNT_W'(pgst_pkg::PAIR_COUNT);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
  localparam logic [SW-1:0]    SQRT_END = SW'(pgst_pkg::SQRT_STEPS - 1);
  localparam logic [SW-1:0]    DIV_END  = SW'(VW - 1);

  pgst_pkg::state_t state, state_next;

  // pointer list
  logic [pgst_pkg::ID_BITS-1:0] slot_id [MAX_POINTERS];
  logic [CW-1:0]                slot_x  [MAX_POINTERS];
  logic [CW-1:0]                slot_y  [MAX_POINTERS];
  logic [CNT_W-1:0]             count;

  // request latch and scan
  logic [pgst_pkg::ID_BITS-1:0] req_id;
  logic [CW-1:0]                req_x, req_y;
  logic                         op_release;
  logic                         emit;
  logic [CNT_W-1:0]             scan_i, kept;

  // arithmetic
  logic [CW-1:0]               dx, dy;
  logic [pgst_pkg::SQ_BITS-1:0] prod;
  logic [RW-1:0]               rad;
  logic [UW-1:0]               rem;
  logic [DW-1:0]               root, root_next;
  logic [VW-1:0]               quot;
  logic [SW-1:0]               step;
  logic [DW-1:0]               base_dist;

  // output register
  logic            out_valid;
  pgst_pkg::res_t  out_data;

  // shared trial subtractor
  logic [UW-1:0] sub_a, sub_b;
  logic [UW:0]   unit_diff;
  logic          unit_ge;

  logic                         accept, is_press, room, scan_live, scan_hit, out_free;
  logic [IDX_W-1:0]             rd_idx;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_idx;
  logic [pgst_pkg::ID_BITS-1:0] wr_id;
  logic [CW-1:0]                wr_x, wr_y;
  logic [CW-1:0]                mul_a;
  logic [QW-1:0]                ratio_val;

  assign evt.ready = (state == pgst_pkg::ST_IDLE);
  assign accept    = evt.valid && evt.ready;
  assign is_press  = (evt.data.command == pgst_pkg::CMD_PRESS);
  assign room      = (count < MAX_CNT);
  assign scan_live = (scan_i < count);
  assign rd_idx    = scan_i[IDX_W-1:0];
  assign scan_hit  = (slot_id[rd_idx] == req_id);
  assign out_free  = !out_valid || res.ready;

  assign res.valid = out_valid;
  assign res.data  = out_data;

  always_comb begin
    if (state == pgst_pkg::ST_DIV) begin
      sub_a = {rem[UW-2:0], rad[VW-1]};
      sub_b = UW'(base_dist);
    end else begin
      sub_a = {rem[UW-3:0], rad[RW-1 -: 2]};
      sub_b = UW'({root, 2'b01});
    end
    unit_diff = {1'b0, sub_a} - {1'b0, sub_b};
    unit_ge   = !unit_diff[UW];
    root_next = {root[DW-2:0], unit_ge};
  end

  always_comb begin
    if (|quot[VW-1:QW]) begin
      ratio_val = '1;
    end else begin
      ratio_val = quot[QW-1:0];
    end
    if (base_dist == '0) begin
      ratio_val = '1;
    end
  end

  assign mul_a = (state == pgst_pkg::ST_SQX) ? dx : dy;

  // list write port
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = count[IDX_W-1:0];
    wr_id  = evt.data.pointer_id;
    wr_x   = evt.data.pos_x;
    wr_y   = evt.data.pos_y;
    case (state)
      pgst_pkg::ST_IDLE: begin
        wr_en = accept && is_press && room;
      end
      pgst_pkg::ST_SCAN: begin
        if (op_release) begin
          wr_en  = scan_live && !scan_hit;
          wr_idx = kept[IDX_W-1:0];
          wr_id  = slot_id[rd_idx];
          wr_x   = slot_x[rd_idx];
          wr_y   = slot_y[rd_idx];
        end else begin
          wr_en  = scan_live && scan_hit;
          wr_idx = rd_idx;
          wr_id  = req_id;
          wr_x   = req_x;
          wr_y   = req_y;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_id[wr_idx] <= wr_id;
      slot_x[wr_idx]  <= wr_x;
      slot_y[wr_idx]  <= wr_y;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      pgst_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_press) begin
            if (room && count == ONE_CNT) begin
              state_next = pgst_pkg::ST_DIFF;
            end
          end else if (evt.data.command == pgst_pkg::CMD_RELEASE ||
                       evt.data.command == pgst_pkg::CMD_MOVE) begin
            state_next = pgst_pkg::ST_SCAN;
          end
        end
      end
      pgst_pkg::ST_SCAN: begin
        if (!scan_live) begin
          if (!op_release && count == PAIR_CNT) begin
            state_next = pgst_pkg::ST_DIFF;
          end else begin
            state_next = pgst_pkg::ST_IDLE;
          end
        end
      end
      pgst_pkg::ST_DIFF: state_next = pgst_pkg::ST_SQX;
      pgst_pkg::ST_SQX:  state_next = pgst_pkg::ST_SQY;
      pgst_pkg::ST_SQY:  state_next = pgst_pkg::ST_SUM;
      pgst_pkg::ST_SUM:  state_next = pgst_pkg::ST_SQRT;
      pgst_pkg::ST_SQRT: begin
        if (step == SQRT_END) begin
          if (!emit) begin
            state_next = pgst_pkg::ST_IDLE;
          end else if (base_dist == '0) begin
            state_next = pgst_pkg::ST_OUT;
          end else begin
            state_next = pgst_pkg::ST_DIV;
          end
        end
      end
      pgst_pkg::ST_DIV: begin
        if (step == DIV_END) begin
          state_next = pgst_pkg::ST_OUT;
        end
      end
      pgst_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = pgst_pkg::ST_IDLE;
        end
      end
      default: state_next = pgst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      base_dist <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == pgst_pkg::ST_IDLE && accept && is_press && room) begin
        count <= count + ONE_CNT;
      end
      if (state == pgst_pkg::ST_SCAN && !scan_live && op_release) begin
        count <= kept;
      end
      if (state == pgst_pkg::ST_SQRT && step == SQRT_END && !emit) begin
        base_dist <= root_next;
      end
      if (state == pgst_pkg::ST_OUT && out_free) begin
        base_dist <= root;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      req_id     <= evt.data.pointer_id;
      req_x      <= evt.data.pos_x;
      req_y      <= evt.data.pos_y;
      op_release <= (evt.data.command == pgst_pkg::CMD_RELEASE);
      emit       <= (evt.data.command == pgst_pkg::CMD_MOVE);
      scan_i     <= '0;
      kept       <= '0;
    end
    case (state)
      pgst_pkg::ST_SCAN: begin
        if (scan_live) begin
          scan_i <= scan_i + ONE_CNT;
          if (op_release && !scan_hit) begin
            kept <= kept + ONE_CNT;
          end
        end
      end
      pgst_pkg::ST_DIFF: begin
        dx <= (slot_x[0] > slot_x[1]) ? slot_x[0] - slot_x[1] : slot_x[1] - slot_x[0];
        dy <= (slot_y[0] > slot_y[1]) ? slot_y[0] - slot_y[1] : slot_y[1] - slot_y[0];
      end
      pgst_pkg::ST_SQX: begin
        prod <= mul_a * mul_a;
      end
      pgst_pkg::ST_SQY: begin
        rad  <= RW'(prod);
        prod <= mul_a * mul_a;
      end
      pgst_pkg::ST_SUM: begin
        rad  <= (rad + RW'(prod)) << pgst_pkg::FRAC_SHIFT;
        rem  <= '0;
        root <= '0;
        step <= '0;
      end
      pgst_pkg::ST_SQRT: begin
        root <= root_next;
        if (step == SQRT_END) begin
          // set up the divide: dividend is distance << 16
          rem  <= '0;
          quot <= '0;
          step <= '0;
          rad  <= RW'({root_next, {pgst_pkg::FRAC_SHIFT{1'b0}}});
        end else begin
          rem  <= unit_ge ? unit_diff[UW-1:0] : sub_a;
          rad  <= rad << 2;
          step <= step + SW'(1);
        end
      end
      pgst_pkg::ST_DIV: begin
        rem  <= unit_ge ? unit_diff[UW-1:0] : sub_a;
        quot <= {quot[VW-2:0], unit_ge};
        rad  <= rad << 1;
        step <= step + SW'(1);
      end
      pgst_pkg::ST_OUT: begin
        if (out_free) begin
          out_data.scale_ratio      <= ratio_val;
          out_data.current_distance <= root;
          out_data.base_was_zero    <= (base_dist == '0);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
